[rtl/fpvn_pkg.sv]
// Package with the shared widths and types of the vector normalizer.
`timescale 1ns / 1ps
package fpvn_pkg;
    localparam int FRAC_BITS = 16;
    localparam int COMP_W = 32;
    localparam int IP_W = COMP_W - FRAC_BITS;
    localparam int SQ_W = 2 * IP_W;
    localparam int SUM_W = SQ_W + 2;
    localparam int ROOT_W = SUM_W / 2;
    localparam int RECIP_W = FRAC_BITS + 1;
    localparam int PROD_W = COMP_W + RECIP_W + 1;

    typedef struct packed {
        logic [COMP_W-1:0] x;
        logic [COMP_W-1:0] y;
        logic [COMP_W-1:0] z;
        logic              zero;
    } t_side;
endpackage

[rtl/fpvn_sq_lane.sv]
// One lane that squares the integer part of a component.
`timescale 1ns / 1ps
module fpvn_sq_lane
    import fpvn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [COMP_W-1:0] i_comp,
    output logic [SQ_W-1:0]   o_sq
);
    logic signed [IP_W-1:0] ip;
    logic [SQ_W-1:0]        r_sq;

    assign ip = i_comp[COMP_W-1:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= SQ_W'(ip * ip);
        end
    end

    assign o_sq = r_sq;
endmodule

[rtl/fpvn_scale_lane.sv]
// One lane that multiplies a component by the reciprocal length.
`timescale 1ns / 1ps
module fpvn_scale_lane
    import fpvn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [COMP_W-1:0]  i_comp,
    input  logic [RECIP_W-1:0] i_recip,
    output logic [COMP_W-1:0]  o_norm
);
    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'($signed(i_comp) * $signed({1'b0, i_recip}));
        end
    end

    assign o_norm = r_prod[FRAC_BITS+COMP_W-1:FRAC_BITS];
endmodule

[rtl/fpvn_root.sv]
// Pipelined square root of the sum followed by a pipelined reciprocal.
`timescale 1ns / 1ps
module fpvn_root
    import fpvn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [SUM_W-1:0]   i_sum,
    input  t_side              i_side,
    output logic               o_valid,
    output logic [RECIP_W-1:0] o_recip,
    output t_side              o_side
);
    localparam int REM_W = ROOT_W + 2;

    logic [SUM_W-1:0]   r_sn   [ROOT_W];
    logic [REM_W-1:0]   r_srem [ROOT_W];
    logic [ROOT_W-1:0]  r_sroot[ROOT_W];
    logic               r_sv   [ROOT_W];
    t_side              r_sside[ROOT_W];
    logic [SUM_W-1:0]   n_sn   [ROOT_W];
    logic [REM_W-1:0]   n_srem [ROOT_W];
    logic [ROOT_W-1:0]  n_sroot[ROOT_W];

    logic [ROOT_W-1:0]  r_dl   [RECIP_W];
    logic [ROOT_W-1:0]  r_drem [RECIP_W];
    logic [RECIP_W-1:0] r_dq   [RECIP_W];
    logic               r_dv   [RECIP_W];
    t_side              r_dside[RECIP_W];
    logic [ROOT_W-1:0]  n_dl   [RECIP_W];
    logic [ROOT_W-1:0]  n_drem [RECIP_W];
    logic [RECIP_W-1:0] n_dq   [RECIP_W];

    always_comb begin
        logic [SUM_W-1:0]  pn;
        logic [REM_W-1:0]  prem;
        logic [ROOT_W-1:0] proot;
        logic [REM_W+1:0]  sh;
        logic [REM_W+1:0]  tst;
        for (int k = 0; k < ROOT_W; k++) begin
            if (k == 0) begin
                pn = i_sum;
                prem = '0;
                proot = '0;
            end else begin
                pn = r_sn[k-1];
                prem = r_srem[k-1];
                proot = r_sroot[k-1];
            end
            sh = {prem, pn[SUM_W-1:SUM_W-2]};
            tst = {2'b00, proot, 2'b01};
            n_sn[k] = {pn[SUM_W-3:0], 2'b00};
            if (sh >= tst) begin
                n_srem[k] = REM_W'(sh - tst);
                n_sroot[k] = {proot[ROOT_W-2:0], 1'b1};
            end else begin
                n_srem[k] = REM_W'(sh);
                n_sroot[k] = {proot[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        logic [ROOT_W-1:0]  pl;
        logic [ROOT_W-1:0]  prem;
        logic [RECIP_W-1:0] pq;
        logic [ROOT_W:0]    rs;
        for (int j = 0; j < RECIP_W; j++) begin
            if (j == 0) begin
                pl = (r_sroot[ROOT_W-1] == '0) ? ROOT_W'(1) : r_sroot[ROOT_W-1];
                prem = '0;
                pq = '0;
            end else begin
                pl = r_dl[j-1];
                prem = r_drem[j-1];
                pq = r_dq[j-1];
            end
            rs = {prem, (j == 0)};
            n_dl[j] = pl;
            if (rs >= {1'b0, pl}) begin
                n_drem[j] = ROOT_W'(rs - {1'b0, pl});
                n_dq[j] = {pq[RECIP_W-2:0], 1'b1};
            end else begin
                n_drem[j] = rs[ROOT_W-1:0];
                n_dq[j] = {pq[RECIP_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ROOT_W; k++) r_sv[k] <= 1'b0;
            for (int j = 0; j < RECIP_W; j++) r_dv[j] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < ROOT_W; k++) r_sv[k] <= (k == 0) ? i_valid : r_sv[k-1];
            for (int j = 0; j < RECIP_W; j++) begin
                r_dv[j] <= (j == 0) ? r_sv[ROOT_W-1] : r_dv[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < ROOT_W; k++) begin
                r_sn[k] <= n_sn[k];
                r_srem[k] <= n_srem[k];
                r_sroot[k] <= n_sroot[k];
                r_sside[k] <= (k == 0) ? i_side : r_sside[k-1];
            end
            for (int j = 0; j < RECIP_W; j++) begin
                r_dl[j] <= n_dl[j];
                r_drem[j] <= n_drem[j];
                r_dq[j] <= n_dq[j];
                r_dside[j] <= (j == 0) ? r_sside[ROOT_W-1] : r_dside[j-1];
            end
        end
    end

    assign o_valid = r_dv[RECIP_W-1];
    assign o_recip = r_dq[RECIP_W-1];
    assign o_side = r_dside[RECIP_W-1];
endmodule

[rtl/fixed_point_vector_normalise.sv]
// Top level of the fixed-point 3D vector normalizer.
// Channel | Direction | Contents
// s_axis  | in        | tdata: vec_x, vec_y, vec_z
// m_axis  | out       | tdata: norm_x, norm_y, norm_z; tuser: was_zero
// One item enters per cycle unless the output stalls. Its result passes through the
// squares and sum, the bit-per-stage square root and reciprocal, scaling and output.
// Reset is synchronous and active low and empties the pipeline.
// A stalled output freezes the whole pipeline and drops s_axis_tready.
`timescale 1ns / 1ps
module fixed_point_vector_normalise
    import fpvn_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [3*COMP_W-1:0]   s_axis_tdata,  // vec_x, vec_y, vec_z
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [3*COMP_W-1:0]   m_axis_tdata,  // norm_x, norm_y, norm_z
    output logic                  m_axis_tuser   // was_zero
);
    logic                en;
    logic [SQ_W-1:0]     sq [3];
    logic [COMP_W-1:0]   comp [3];
    logic [COMP_W-1:0]   norm [3];
    logic                r_a_v, r_b_v, r_c_v, r_o_v;
    t_side               r_a_side, r_b_side, r_c_side, in_side, rt_side;
    logic [SUM_W-1:0]    r_b_sum;
    logic                rt_valid;
    logic [RECIP_W-1:0]  rt_recip;
    logic [3*COMP_W-1:0] r_o_data;
    logic                r_o_zero;

    assign en = m_axis_tready || !r_o_v;
    assign s_axis_tready = en;

    assign comp[0] = s_axis_tdata[COMP_W-1:0];
    assign comp[1] = s_axis_tdata[2*COMP_W-1:COMP_W];
    assign comp[2] = s_axis_tdata[3*COMP_W-1:2*COMP_W];

    assign in_side.x = comp[0];
    assign in_side.y = comp[1];
    assign in_side.z = comp[2];
    assign in_side.zero = ~|{comp[0][COMP_W-1:FRAC_BITS], comp[1][COMP_W-1:FRAC_BITS],
                             comp[2][COMP_W-1:FRAC_BITS]};

    for (genvar g = 0; g < 3; g++) begin : g_sq
        fpvn_sq_lane u_sq (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_comp (comp[g]),
            .o_sq   (sq[g])
        );
    end

    fpvn_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_v),
        .i_sum   (r_b_sum),
        .i_side  (r_b_side),
        .o_valid (rt_valid),
        .o_recip (rt_recip),
        .o_side  (rt_side)
    );

    fpvn_scale_lane u_sc_x (
        .i_clk (i_clk), .i_en (en), .i_comp (rt_side.x), .i_recip (rt_recip),
        .o_norm (norm[0])
    );
    fpvn_scale_lane u_sc_y (
        .i_clk (i_clk), .i_en (en), .i_comp (rt_side.y), .i_recip (rt_recip),
        .o_norm (norm[1])
    );
    fpvn_scale_lane u_sc_z (
        .i_clk (i_clk), .i_en (en), .i_comp (rt_side.z), .i_recip (rt_recip),
        .o_norm (norm[2])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (en) begin
            r_a_v <= s_axis_tvalid;
            r_b_v <= r_a_v;
            r_c_v <= rt_valid;
            r_o_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_side <= in_side;
            r_b_side <= r_a_side;
            r_b_sum <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
            r_c_side <= rt_side;
            r_o_zero <= r_c_side.zero;
            if (r_c_side.zero) begin
                r_o_data <= {r_c_side.z, r_c_side.y, r_c_side.x};
            end else begin
                r_o_data <= {norm[2], norm[1], norm[0]};
            end
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata = r_o_data;
    assign m_axis_tuser = r_o_zero;

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (m_axis_tready || !m_axis_tvalid))
        else $error("input ready does not follow the output stall");
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_c_v) |=> m_axis_tvalid)
        else $error("result lost between last stages");
endmodule

[tb/sv/fixed_point_vector_normalise_test.sv]
// Testbench for the fixed-point vector normalizer: random and directed vectors checked in order.
`timescale 1ns / 1ps
module fixed_point_vector_normalise_test;
    import fpvn_pkg::*;

    typedef struct packed {
        logic [COMP_W-1:0] x;
        logic [COMP_W-1:0] y;
        logic [COMP_W-1:0] z;
        logic              zero;
    } t_norm;

    class norm_scoreboard;
        t_norm pending[$];
        int    errors = 0;

        function automatic longint floor_shift(longint v);
            return v >>> FRAC_BITS;
        endfunction

        function automatic longint root_floor(longint n);
            longint lo;
            longint hi;
            longint mid;
            lo = 0;
            hi = 64'd3037000499;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (mid * mid <= n) lo = mid;
                else hi = mid - 1;
            end
            return lo;
        endfunction

        function void note_vector(logic [COMP_W-1:0] vx, logic [COMP_W-1:0] vy,
                                  logic [COMP_W-1:0] vz);
            longint comp[3];
            longint ip[3];
            longint sum;
            longint len;
            longint recip;
            longint q[3];
            t_norm  e;
            comp[0] = longint'($signed(vx));
            comp[1] = longint'($signed(vy));
            comp[2] = longint'($signed(vz));
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                ip[i] = floor_shift(comp[i]);
                sum += ip[i] * ip[i];
            end
            if (ip[0] == 0 && ip[1] == 0 && ip[2] == 0) begin
                e = '{vx, vy, vz, 1'b1};
            end else begin
                len = root_floor(sum);
                if (len == 0) len = 1;
                recip = (longint'(1) << FRAC_BITS) / len;
                for (int i = 0; i < 3; i++) q[i] = floor_shift(comp[i] * recip);
                e = '{q[0][31:0], q[1][31:0], q[2][31:0], 1'b0};
            end
            pending.push_back(e);
        endfunction

        function void check_result(t_norm got);
            t_norm e;
            if (pending.size() == 0) begin
                $error("result with no expectation: %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.x !== e.x) begin
                $error("norm_x expected %h got %h", e.x, got.x);
                errors++;
            end
            if (got.y !== e.y) begin
                $error("norm_y expected %h got %h", e.y, got.y);
                errors++;
            end
            if (got.z !== e.z) begin
                $error("norm_z expected %h got %h", e.z, got.z);
                errors++;
            end
            if (got.zero !== e.zero) begin
                $error("was_zero expected %b got %b", e.zero, got.zero);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [3*COMP_W-1:0] s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [3*COMP_W-1:0] m_axis_tdata;
    logic                m_axis_tuser;

    norm_scoreboard board = new();
    int send_idle = 0;
    int recv_stall = 0;
    int hold_off = 0;
    int quiet = 0;

    localparam int LATENCY = ROOT_W + RECIP_W + 4;
    localparam int WATCHDOG = 20000;

    always #1 i_clk = ~i_clk;

    fixed_point_vector_normalise i_dut (.*);

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result({m_axis_tdata[COMP_W-1:0], m_axis_tdata[2*COMP_W-1:COMP_W],
                                m_axis_tdata[3*COMP_W-1:2*COMP_W], m_axis_tuser});
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > WATCHDOG) begin
            $display("fixed_point_vector_normalise_test: errors");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    function automatic logic [COMP_W-1:0] rand_comp();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(65535);
            2: return -$urandom_range(65536);
            3: return $urandom_range(4) << FRAC_BITS | $urandom_range(65535);
            4: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return ($urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000) ^ $urandom_range(3);
        endcase
    endfunction

    task automatic send_vector(logic [COMP_W-1:0] vx, logic [COMP_W-1:0] vy,
                               logic [COMP_W-1:0] vz);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {vz, vy, vx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_vector(vx, vy, vz);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() > 0) @(negedge i_clk);
    endtask

    initial begin
        logic [COMP_W-1:0] corner[8];
        corner = '{32'h0, 32'h0000FFFF, 32'hFFFF0000, 32'hFFFFFFFF, 32'h00010000,
                   32'h7FFFFFFF, 32'h80000000, 32'h80000001};
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int i = 0; i < 8; i++) send_vector(corner[i], corner[(i + 3) % 8], corner[7 - i]);
        send_vector(32'h0, 32'h0000FFFF, 32'h0);
        send_vector(32'h80000000, 32'h80000000, 32'h80000000);
        send_vector(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_vector(32'h00030000, 32'h00040000, 32'h0);
        send_vector(32'hFFFFFFFF, 32'h0, 32'h0);
        send_vector(32'h0, 32'h0, 32'h00000001);
        drain();
        for (int phase = 0; phase < 4; phase++) begin
            send_idle = (phase == 1) ? 46 : (phase == 3) ? 11 : 0;
            recv_stall = (phase == 2) ? 46 : (phase == 3) ? 11 : 0;
            if (phase == 2) hold_off = 200;
            for (int n = 0; n < 425; n++) send_vector(rand_comp(), rand_comp(), rand_comp());
            drain();
        end
        repeat (LATENCY + 10) @(negedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("fixed_point_vector_normalise_test: clean");
        else
            $display("fixed_point_vector_normalise_test: errors");
        $finish;
    end
endmodule
